### rtl/core/isp_pkg.sv
package isp_pkg;

  localparam int DEF_BUFFER_BYTES    = 4096;
  localparam int DEF_PALETTE_ENTRIES = 256;

  // position compare width: covers row*width + column and BUFFER_BYTES up to 65536
  localparam int CMP_W      = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [1:0] FUNC_PALETTE = 2'd0;
  localparam logic [1:0] FUNC_PIXEL   = 2'd1;
  localparam logic [1:0] FUNC_DRAIN   = 2'd2;

  localparam logic [1:0] MODE_2BIT = 2'd0;
  localparam logic [1:0] MODE_4BIT = 2'd1;
  localparam logic [1:0] MODE_GREY = 2'd2;
  localparam logic [1:0] MODE_8BIT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANAR_LAYOUT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDENTITY_COLORS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_HEIGHT    = 3'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  entry_index;
    logic [31:0] payload;
  } isp_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_shape;
    logic       status;
  } isp_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_DECIDE,
    ST_FETCH,
    ST_DONE
  } st_t;

endpackage

### rtl/core/indexed_shape_to_planar_packer.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  in_data   (func, entry_index, payload)
// out      output     out_valid / out_ready out_data (out_byte, last_of_shape, status)
// cfg      input      cfg_wr_en            cfg_index, cfg_wdata
//
// Palette and pixel transactions are written when accepted. A drain transaction fetches
// n = 1, 2, 4 or 8 pixels one per cycle through the shape buffer and color table read ports
// (8 for bit-plane bytes) and lets the read pipeline empty; a drain answered with status 1
// skips the fetch. A shared 8x8 multiplier forms width*height, then the row base address.
// Synchronous reset clears the control state and loads the register defaults; memories
// hold no reset value. A waiting result does not block palette or pixel transactions; a
// drain finishing while the output register is still full waits for it to empty.
module indexed_shape_to_planar_packer #(
  parameter int BUFFER_BYTES    = isp_pkg::DEF_BUFFER_BYTES,
  parameter int PALETTE_ENTRIES = isp_pkg::DEF_PALETTE_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  isp_pkg::isp_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output isp_pkg::isp_out_t              out_data,
  input  logic                           cfg_wr_en,
  input  logic [isp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [isp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import isp_pkg::*;

  localparam int BUF_AW = $clog2(BUFFER_BYTES);
  localparam int PL_W   = BUF_AW + 1;
  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  logic [1:0] video_mode;
  logic       planar_layout;
  logic       identity_colors;
  logic [7:0] shape_width;
  logic [7:0] shape_height;

  logic [7:0] ctab [PALETTE_ENTRIES];
  logic [7:0] sbuf [BUFFER_BYTES];

  logic [PL_W-1:0] pixels_loaded;
  logic [1:0]      drain_plane;
  logic [7:0]      drain_row;
  logic [7:0]      drain_column;
  logic            finished;

  st_t state, state_next;

  logic [15:0] prod;
  logic [7:0]  mul_b;
  logic [2:0]  k;
  logic [7:0]  acc;
  logic        res_ok;

  logic       s1_valid, s1_zero;
  logic [2:0] s1_k;
  logic [7:0] buf_q;
  logic       s2_valid, s2_zero;
  logic [2:0] s2_k;
  logic [7:0] s2_raw, pal_q;

  logic            in_acc, slot_free, fetch_en, emit, pix_wr, pal_wr;
  logic            clear_shape, draining_ok, loaded_ok, pos_out;
  logic [PL_W-1:0] wr_ptr;
  logic [8:0]      w9;
  logic [7:0]      per_row;
  logic [2:0]      planes, k_last;
  logic [10:0]     x_base, x;
  logic [CMP_W-1:0] addr;
  logic            x_oob, a_oob;
  logic [8:0]      col_inc, row_inc;
  logic [2:0]      plane_inc;
  logic            col_wrap, row_wrap, plane_wrap, fin_after;
  logic [7:0]      pal_val, color, contrib;

  assign in_acc    = in_valid & in_ready;
  assign slot_free = !out_valid || out_ready;
  assign w9        = {1'b0, shape_width};

  // layout geometry
  always_comb begin
    case (video_mode)
      MODE_2BIT: begin
        per_row = 8'((w9 + 9'd3) >> 2);
        planes  = 3'd1;
        k_last  = 3'd3;
        x_base  = 11'({drain_column, 2'b00});
      end
      MODE_4BIT, MODE_GREY: begin
        if (planar_layout) begin
          per_row = 8'((w9 + 9'd7) >> 3);
          planes  = 3'd4;
          k_last  = 3'd7;
          x_base  = 11'({drain_column, 3'b000});
        end else begin
          per_row = 8'((w9 + 9'd1) >> 1);
          planes  = 3'd1;
          k_last  = 3'd1;
          x_base  = 11'({drain_column, 1'b0});
        end
      end
      default: begin
        if (planar_layout) begin
          per_row = 8'((w9 + 9'd3) >> 2);
          planes  = 3'd4;
          k_last  = 3'd0;
          x_base  = 11'({drain_column, ~drain_plane});
        end else begin
          per_row = shape_width;
          planes  = 3'd1;
          k_last  = 3'd0;
          x_base  = 11'(drain_column);
        end
      end
    endcase
  end

  assign loaded_ok = (CMP_W'(pixels_loaded) >= CMP_W'(prod)) ||
                     (pixels_loaded >= PL_W'(BUFFER_BYTES));
  assign pos_out   = ({1'b0, drain_plane} >= planes) || (drain_row >= shape_height) ||
                     (drain_column >= per_row);
  assign draining_ok = !finished && loaded_ok && !pos_out;

  assign x     = x_base + 11'(k);
  assign x_oob = x >= 11'(shape_width);
  assign addr  = CMP_W'(prod) + CMP_W'(x);
  assign a_oob = addr >= CMP_W'(BUFFER_BYTES);

  assign col_inc    = 9'(drain_column) + 9'd1;
  assign col_wrap   = col_inc >= {1'b0, per_row};
  assign row_inc    = 9'(drain_row) + 9'd1;
  assign row_wrap   = row_inc >= {1'b0, shape_height};
  assign plane_inc  = 3'(drain_plane) + 3'd1;
  assign plane_wrap = plane_inc >= planes;
  assign fin_after  = col_wrap && row_wrap && plane_wrap;

  assign clear_shape = finished || (drain_plane != 2'd0) || (drain_row != 8'd0) ||
                       (drain_column != 8'd0);
  assign wr_ptr      = clear_shape ? '0 : pixels_loaded;
  assign pix_wr      = in_acc && (in_data.func == FUNC_PIXEL) &&
                       (wr_ptr < PL_W'(BUFFER_BYTES));
  assign pal_wr      = in_acc && (in_data.func == FUNC_PALETTE) &&
                       ({1'b0, in_data.entry_index} < 9'(PALETTE_ENTRIES));

  always_comb begin
    case (video_mode)
      MODE_2BIT: pal_val = {6'd0, in_data.payload[1:0]};
      MODE_4BIT: pal_val = {4'd0, in_data.payload[11:8]};
      default:   pal_val = in_data.payload[23:16];
    endcase
  end

  // color of the pixel leaving the read pipeline and its place in the byte
  always_comb begin
    if (s2_zero) begin
      color = 8'd0;
    end else if (identity_colors) begin
      color = s2_raw;
    end else if ({1'b0, s2_raw} >= 9'(PALETTE_ENTRIES)) begin
      color = 8'd0;
    end else begin
      color = pal_q;
    end
    case (video_mode)
      MODE_2BIT: contrib = color << {~s2_k[1:0], 1'b0};
      MODE_4BIT, MODE_GREY: begin
        if (planar_layout) begin
          contrib = ((color & (8'h08 >> drain_plane)) != 8'd0) ? (8'h80 >> s2_k) : 8'd0;
        end else begin
          contrib = s2_k[0] ? (color << 4) : color;
        end
      end
      default: contrib = color;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && (in_data.func == FUNC_DRAIN)) state_next = ST_TOTAL;
      end
      ST_TOTAL:  state_next = ST_DECIDE;
      ST_DECIDE: state_next = draining_ok ? ST_FETCH : ST_DONE;
      ST_FETCH: begin
        if (k == k_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!s1_valid && !s2_valid && slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    fetch_en = (state == ST_FETCH);
    emit     = (state == ST_DONE) && !s1_valid && !s2_valid && slot_free;
    mul_b    = (state == ST_TOTAL) ? shape_height : drain_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      video_mode      <= MODE_8BIT;
      planar_layout   <= 1'b0;
      identity_colors <= 1'b1;
      shape_width     <= 8'd16;
      shape_height    <= 8'd16;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_VIDEO_MODE:      video_mode      <= cfg_wdata[1:0];
        CFG_PLANAR_LAYOUT:   planar_layout   <= cfg_wdata[0];
        CFG_IDENTITY_COLORS: identity_colors <= cfg_wdata[0];
        CFG_SHAPE_WIDTH:     shape_width     <= cfg_wdata;
        CFG_SHAPE_HEIGHT:    shape_height    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pixels_loaded <= '0;
      drain_plane   <= 2'd0;
      drain_row     <= 8'd0;
      drain_column  <= 8'd0;
      finished      <= 1'b0;
      k             <= 3'd0;
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      out_valid     <= 1'b0;
      res_ok        <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= fetch_en;
      s2_valid <= s1_valid;

      if (in_acc && (in_data.func == FUNC_PIXEL)) begin
        if (clear_shape) begin
          drain_plane  <= 2'd0;
          drain_row    <= 8'd0;
          drain_column <= 8'd0;
          finished     <= 1'b0;
        end
        pixels_loaded <= pix_wr ? wr_ptr + PL_W'(1) : wr_ptr;
      end

      if (state == ST_DECIDE) begin
        k      <= 3'd0;
        res_ok <= draining_ok;
        if (!finished && loaded_ok && pos_out) finished <= 1'b1;
      end else if (fetch_en) begin
        k <= k + 3'd1;
      end

      if (emit && res_ok) begin
        drain_column <= col_wrap ? 8'd0 : col_inc[7:0];
        if (col_wrap) begin
          drain_row <= row_wrap ? 8'd0 : row_inc[7:0];
          if (row_wrap) drain_plane <= plane_wrap ? 2'd0 : plane_inc[1:0];
        end
        finished <= fin_after;
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod    <= {8'd0, shape_width} * {8'd0, mul_b};
    s1_k    <= k;
    s1_zero <= x_oob || a_oob;
    s2_k    <= s1_k;
    s2_zero <= s1_zero;
    s2_raw  <= buf_q;
    if (state == ST_DECIDE) begin
      acc <= 8'd0;
    end else if (s2_valid) begin
      acc <= acc | contrib;
    end
    if (emit) begin
      out_data.out_byte      <= res_ok ? acc : 8'd0;
      out_data.last_of_shape <= res_ok && fin_after;
      out_data.status        <= !res_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_wr) sbuf[wr_ptr[BUF_AW-1:0]] <= in_data.payload[7:0];
    buf_q <= sbuf[addr[BUF_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pal_wr) ctab[in_data.entry_index[PAL_AW-1:0]] <= pal_val;
    pal_q <= ctab[buf_q[PAL_AW-1:0]];
  end

endmodule

### rtl/core/isp_checker.sv
module isp_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input isp_pkg::isp_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input isp_pkg::isp_out_t out_data
);
  import isp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.out_byte == 8'd0 && !out_data.last_of_shape)
    else $error("status-1 result carries data");

  a_drain_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.func == FUNC_DRAIN |=> !in_ready)
    else $error("ready after drain transaction");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind indexed_shape_to_planar_packer isp_checker u_isp_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import isp_pkg::*;

  localparam int          SHAPE_BYTES    = DEF_BUFFER_BYTES;
  localparam int          COLOR_ENTRIES  = DEF_PALETTE_ENTRIES;
  localparam int          RANDOM_ITEMS   = 900;
  localparam int          SETTLE_CYCLES  = 20;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          HOLD_AT_RESULT = 100;
  localparam int          QUIET_LIMIT    = 3000;
  localparam logic [1:0]  FUNC_NONE      = 2'd3;

  typedef enum logic { ROW_ITEM, ROW_SET } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    isp_in_t              item;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [7:0]           reg_val;
    logic                 typed;
    isp_out_t             want;
  } dir_row_t;

  localparam isp_in_t  NO_ITEM   = '0;
  localparam isp_in_t  DRAIN     = '{FUNC_DRAIN, 8'h00, 32'h0000_0000};
  localparam isp_out_t NOT_READY = '{8'h00, 1'b0, 1'b1};
  localparam isp_out_t NONE_OUT  = '0;

  localparam dir_row_t DIRECTED [30] = '{
    '{ROW_ITEM, DRAIN, CFG_VIDEO_MODE, 8'h00, 1'b1, NOT_READY},
    '{ROW_SET, NO_ITEM, CFG_SHAPE_WIDTH, 8'd1, 1'b0, NONE_OUT},
    '{ROW_SET, NO_ITEM, CFG_SHAPE_HEIGHT, 8'd1, 1'b0, NONE_OUT},
    '{ROW_ITEM, '{FUNC_PIXEL, 8'h00, 32'hFFFF_FFFF}, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_ITEM, DRAIN, CFG_VIDEO_MODE, 8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0}},
    '{ROW_ITEM, DRAIN, CFG_VIDEO_MODE, 8'h00, 1'b1, NOT_READY},
    '{ROW_ITEM, '{FUNC_NONE, 8'hFF, 32'hFFFF_FFFF}, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_ITEM, '{FUNC_PALETTE, 8'hFF, 32'hFFFF_FFFF}, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_ITEM, '{FUNC_PALETTE, 8'h00, 32'h0000_0000}, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_SET, NO_ITEM, CFG_IDENTITY_COLORS, 8'd0, 1'b0, NONE_OUT},
    '{ROW_ITEM, '{FUNC_PIXEL, 8'h00, 32'h0000_00FF}, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_ITEM, DRAIN, CFG_VIDEO_MODE, 8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0}},
    '{ROW_SET, NO_ITEM, CFG_IDENTITY_COLORS, 8'd1, 1'b0, NONE_OUT},
    '{ROW_SET, NO_ITEM, CFG_VIDEO_MODE, 8'(MODE_2BIT), 1'b0, NONE_OUT},
    '{ROW_SET, NO_ITEM, CFG_SHAPE_WIDTH, 8'd5, 1'b0, NONE_OUT},
    '{ROW_ITEM, '{FUNC_PIXEL, 8'h00, 32'h8000_0003}, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_ITEM, '{FUNC_PIXEL, 8'h00, 32'h0000_0002}, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_ITEM, '{FUNC_PIXEL, 8'h00, 32'h0000_0001}, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_ITEM, '{FUNC_PIXEL, 8'h00, 32'h0000_0000}, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_ITEM, '{FUNC_PIXEL, 8'h00, 32'h0000_0003}, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_ITEM, DRAIN, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_ITEM, DRAIN, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_ITEM, DRAIN, CFG_VIDEO_MODE, 8'h00, 1'b1, NOT_READY},
    '{ROW_SET, NO_ITEM, CFG_VIDEO_MODE, 8'(MODE_8BIT), 1'b0, NONE_OUT},
    '{ROW_SET, NO_ITEM, CFG_SHAPE_WIDTH, 8'd2, 1'b0, NONE_OUT},
    '{ROW_ITEM, '{FUNC_PIXEL, 8'h00, 32'h0000_0012}, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_ITEM, '{FUNC_PIXEL, 8'h00, 32'h0000_0034}, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_ITEM, DRAIN, CFG_VIDEO_MODE, 8'h00, 1'b1, '{8'h12, 1'b0, 1'b0}},
    '{ROW_ITEM, '{FUNC_PIXEL, 8'h00, 32'h0000_0056}, CFG_VIDEO_MODE, 8'h00, 1'b0, NONE_OUT},
    '{ROW_ITEM, DRAIN, CFG_VIDEO_MODE, 8'h00, 1'b1, NOT_READY}
  };

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  isp_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  isp_out_t             out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = '0;

  // shadow of the packer
  logic [7:0]  color_tbl [COLOR_ENTRIES];
  logic [7:0]  shape_mem [SHAPE_BYTES];
  int unsigned loaded     = 0;
  int unsigned d_plane    = 0;
  int unsigned d_row      = 0;
  int unsigned d_col      = 0;
  bit          shape_done = 1'b0;
  bit          last_stat  = 1'b0;
  logic [1:0]  cur_mode   = MODE_8BIT;
  bit          cur_planar = 1'b0;
  bit          cur_ident  = 1'b1;
  int unsigned cur_w      = 16;
  int unsigned cur_h      = 16;

  isp_out_t    expected_bytes [$];
  int unsigned errors       = 0;
  int unsigned results_seen = 0;
  int unsigned items_taken  = 0;
  int unsigned quiet        = 0;
  bit          no_gaps      = 1'b0;

  indexed_shape_to_planar_packer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] pixel_color(input int unsigned x, input int unsigned y);
    int unsigned addr;
    logic [7:0]  idx;
    if (x >= cur_w) return 8'h00;
    addr = y * cur_w + x;
    if (addr >= SHAPE_BYTES) return 8'h00;
    idx = shape_mem[addr];
    return cur_ident ? idx : color_tbl[idx];
  endfunction

  function automatic bit pack_transaction(input isp_in_t t, output isp_out_t r);
    int unsigned total, planes, per_row;
    logic [7:0]  b, mask;
    r = NOT_READY;
    case (t.func)
      FUNC_PALETTE: begin
        if (cur_mode == MODE_2BIT) color_tbl[t.entry_index] = {6'd0, t.payload[1:0]};
        else if (cur_mode == MODE_4BIT) color_tbl[t.entry_index] = {4'd0, t.payload[11:8]};
        else color_tbl[t.entry_index] = t.payload[23:16];
        return 1'b0;
      end
      FUNC_PIXEL: begin
        if (shape_done || d_plane != 0 || d_row != 0 || d_col != 0) begin
          loaded = 0;
          d_plane = 0;
          d_row = 0;
          d_col = 0;
          shape_done = 1'b0;
        end
        if (loaded < SHAPE_BYTES) begin
          shape_mem[loaded] = t.payload[7:0];
          loaded++;
        end
        return 1'b0;
      end
      FUNC_DRAIN: ;
      default: return 1'b0;
    endcase

    last_stat = 1'b1;
    total = cur_w * cur_h;
    if (total > SHAPE_BYTES) total = SHAPE_BYTES;
    if (shape_done || loaded < total) return 1'b1;
    if (cur_mode == MODE_2BIT) begin
      planes = 1;
      per_row = (cur_w + 3) / 4;
    end else if (cur_mode != MODE_8BIT) begin
      planes = cur_planar ? 4 : 1;
      per_row = cur_planar ? (cur_w + 7) / 8 : (cur_w + 1) / 2;
    end else begin
      planes = cur_planar ? 4 : 1;
      per_row = cur_planar ? (cur_w + 3) / 4 : cur_w;
    end
    // position left outside a reconfigured shape
    if (d_plane >= planes || d_row >= cur_h || d_col >= per_row) begin
      shape_done = 1'b1;
      return 1'b1;
    end

    b = 8'h00;
    case (cur_mode)
      MODE_2BIT: begin
        for (int k = 0; k < 4; k++)
          b |= 8'(pixel_color(d_col * 4 + k, d_row) << (6 - 2 * k));
      end
      MODE_4BIT, MODE_GREY: begin
        if (!cur_planar) begin
          b = pixel_color(d_col * 2, d_row) | 8'(pixel_color(d_col * 2 + 1, d_row) << 4);
        end else begin
          mask = 8'h08 >> d_plane;
          for (int k = 0; k < 8; k++)
            if ((pixel_color(d_col * 8 + k, d_row) & mask) != 0) b[7 - k] = 1'b1;
        end
      end
      default: begin
        if (!cur_planar) b = pixel_color(d_col, d_row);
        else b = pixel_color(d_col * 4 + 3 - d_plane, d_row);
      end
    endcase

    d_col++;
    if (d_col >= per_row) begin
      d_col = 0;
      d_row++;
      if (d_row >= cur_h) begin
        d_row = 0;
        d_plane++;
        if (d_plane >= planes) begin
          d_plane = 0;
          shape_done = 1'b1;
        end
      end
    end
    r = '{b, shape_done, 1'b0};
    last_stat = 1'b0;
    return 1'b1;
  endfunction

  task automatic offer(input isp_in_t t, input bit typed, input isp_out_t want);
    int unsigned gap;
    isp_out_t    r;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    if (pack_transaction(t, r)) expected_bytes.push_back(typed ? want : r);
    if (t.func != FUNC_NONE) items_taken++;
  endtask

  task automatic offer_rand(input logic [1:0] func);
    offer('{func, 8'($urandom), 32'($urandom)}, 1'b0, NONE_OUT);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_VIDEO_MODE:      cur_mode = val[1:0];
      CFG_PLANAR_LAYOUT:   cur_planar = val[0];
      CFG_IDENTITY_COLORS: cur_ident = val[0];
      CFG_SHAPE_WIDTH:     cur_w = val;
      CFG_SHAPE_HEIGHT:    cur_h = val;
      default: ;
    endcase
  endtask

  task automatic offer_stray();
    case ($urandom_range(0, 9))
      0, 1, 2: offer_rand(FUNC_PALETTE);
      3, 4, 5, 6: offer_rand(FUNC_PIXEL);
      7, 8: offer_rand(FUNC_DRAIN);
      default: offer_rand(FUNC_NONE);
    endcase
  endtask

  task automatic shape_phase(input bit write_all);
    int unsigned w, h, n, cap, cnt;
    settle();
    if (write_all || $urandom_range(0, 1)) set_reg(CFG_VIDEO_MODE, 8'($urandom_range(0, 3)));
    if (write_all || $urandom_range(0, 1)) set_reg(CFG_PLANAR_LAYOUT, 8'($urandom_range(0, 1)));
    if (write_all || $urandom_range(0, 1)) set_reg(CFG_IDENTITY_COLORS, 8'($urandom_range(0, 1)));
    if (write_all || $urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 9))
        0: begin w = 255; h = 1; end
        1: begin w = 1; h = $urandom_range(1, 255); end
        2: begin w = $urandom_range(17, 60); h = $urandom_range(1, 4); end
        default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 8); end
      endcase
      set_reg(CFG_SHAPE_WIDTH, 8'(w));
      set_reg(CFG_SHAPE_HEIGHT, 8'(h));
    end
    no_gaps = ($urandom_range(0, 4) == 0);

    if ($urandom_range(0, 99) < 75) begin
      n = cur_w * cur_h;
      if (n > SHAPE_BYTES) n = SHAPE_BYTES;
      if ($urandom_range(0, 7) == 0) n += $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 11) == 0) offer_stray();
        offer_rand(FUNC_PIXEL);
      end
      // sometimes leave the shape half drained for the next setting
      cap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 20) : 32'hFFFF_FFFF;
      cnt = 0;
      do begin
        offer(DRAIN, 1'b0, NONE_OUT);
        cnt++;
      end while (!shape_done && !last_stat && cnt < cap);
      repeat ($urandom_range(0, 2)) offer(DRAIN, 1'b0, NONE_OUT);
    end else begin
      repeat ($urandom_range(8, 30)) offer_stray();
    end
  endtask

  always @(posedge clk) begin
    isp_out_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output transaction: out_byte %0h last_of_shape %0b status %0b",
               out_data.out_byte, out_data.last_of_shape, out_data.status);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_data.out_byte);
          errors++;
        end
        if (out_data.last_of_shape !== want.last_of_shape) begin
          $error("last_of_shape: expected %0b, got %0b", want.last_of_shape,
                 out_data.last_of_shape);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0b, got %0b", want.status, out_data.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned hold;
    bit          held;
    held = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 10);
      // long back-pressure while the sender keeps going
      if (!held && results_seen >= HOLD_AT_RESULT) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int unsigned base;
    for (int i = 0; i < COLOR_ENTRIES; i++) color_tbl[i] = 8'h00;
    for (int i = 0; i < SHAPE_BYTES; i++) shape_mem[i] = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_SET) begin
        settle();
        set_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
      end else begin
        offer(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    // every color entry gets written before the random shape phases
    for (int i = 0; i < COLOR_ENTRIES; i++)
      offer('{FUNC_PALETTE, 8'(i), 32'($urandom)}, 1'b0, NONE_OUT);

    base = items_taken;
    shape_phase(1'b1);
    while (items_taken - base < RANDOM_ITEMS) shape_phase(1'b0);

    settle();
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/isp_pkg.sv
rtl/core/indexed_shape_to_planar_packer.sv
rtl/core/isp_checker.sv
sim/tb_top.sv
